/* src/weighted_draw_without_replacement_core_macros.svh */
`ifndef WEIGHTED_DRAW_WITHOUT_REPLACEMENT_CORE_MACROS_SVH
`define WEIGHTED_DRAW_WITHOUT_REPLACEMENT_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define WDWR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wdwr: same-cycle check failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define WDWR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wdwr: next-cycle check failed");

`endif

/* src/wdwr_pkg.sv */
package wdwr_pkg;

  localparam int IDX_FW      = 6;
  localparam int WGT_W       = 16;
  localparam int RND_W       = 31;
  localparam int RAND_WORDS  = 3;
  localparam int CAT_W       = 7;
  localparam int SLOT_W      = 2;
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 8;
  localparam int DIV_CNT_W   = $clog2(RND_W + 1);

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_ROLL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_SCAN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic roll_start;
    logic sum_start;
    logic sum_en;
    logic div_start;
    logic div_en;
    logic scan_start;
    logic scan_en;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic found;
    logic total_zero;
    logic div_done;
    logic scan_hit;
    logic last_pick;
    logic out_free;
  } stat_t;

endpackage

/* src/weighted_draw_without_replacement_core.sv */
// Weighted draw without replacement. A load item (tuser 0) writes one weight
// into the table; a roll item (tuser 1) yields PICKS results, one per pick,
// the last one flagged by tlast. Each pick walks the table once to sum the
// untaken weights (one memory read per cycle), runs a bit-serial remainder
// of the random word by that sum (skipped when the sum is zero or nothing is
// left), walks the table again until the running remainder goes negative and
// hands its result to the output register, waiting while the consumer stalls.
// New items are taken only between rolls; results of a finished roll may
// still wait in the output register. The catalogue size is written through
// cfg_valid/cfg_data, which is always ready; values above MAX_ENTRIES act as
// MAX_ENTRIES. Weights of entries never loaded are undefined and must not be
// drawn from.
module weighted_draw_without_replacement_core #(
  parameter int MAX_ENTRIES = 64,
  parameter int PICKS       = 3
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // entry_index[5:0], entry_weight[21:6], random_first[52:22],
  // random_second[83:53], random_third[114:84], zero fill [119:115]
  input  logic [wdwr_pkg::IN_TDATA_W-1:0]  in_tdata,
  // action[0]
  input  logic                             in_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wdwr_pkg::CAT_W-1:0]       cfg_data,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // card_valid[0], card_index[6:1], zero fill [7]
  output logic [wdwr_pkg::OUT_TDATA_W-1:0] out_tdata,
  // slot[1:0]
  output logic [wdwr_pkg::SLOT_W-1:0]      out_tuser,
  output logic                             out_tlast
);
  import wdwr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  wdwr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wdwr_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .PICKS       (PICKS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

/* src/wdwr_ctrl.sv */
module wdwr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            in_tuser,
  output logic            in_tready,
  input  wdwr_pkg::stat_t stat,
  output wdwr_pkg::cmd_t  cmd
);
  import wdwr_pkg::*;

  state_t state_r, state_nxt;
  logic   in_acc;

  assign in_acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tuser == ACT_ROLL) state_nxt = ST_SUM;
      end
      ST_SUM: begin
        if (stat.walk_done) begin
          if (stat.found && !stat.total_zero) state_nxt = ST_DIV;
          else state_nxt = ST_OUT;
        end
      end
      ST_DIV: begin
        if (stat.div_done) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_hit || stat.walk_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (stat.out_free) state_nxt = stat.last_pick ? ST_IDLE : ST_SUM;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // tready is high throughout idle, so tvalid alone marks an accepted item there
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && in_tuser == ACT_LOAD) cmd.load = 1'b1;
        if (in_tvalid && in_tuser == ACT_ROLL) begin
          cmd.roll_start = 1'b1;
          cmd.sum_start  = 1'b1;
        end
      end
      ST_SUM: begin
        cmd.sum_en = 1'b1;
        if (stat.walk_done && stat.found && !stat.total_zero) cmd.div_start = 1'b1;
      end
      ST_DIV: begin
        cmd.div_en = 1'b1;
        if (stat.div_done) cmd.scan_start = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (!stat.last_pick) cmd.sum_start = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `include "weighted_draw_without_replacement_core_macros.svh"

  `WDWR_ASSERT_NOW(a_emit_has_room, cmd.emit, stat.out_free)
  `WDWR_ASSERT_NEXT(a_div_runs, cmd.div_start, !stat.div_done)
  `WDWR_ASSERT_NEXT(a_roll_ends_idle, cmd.emit && stat.last_pick, in_tready)

endmodule

/* src/wdwr_dp.sv */
module wdwr_dp #(
  parameter int MAX_ENTRIES = 64,
  parameter int PICKS       = 3
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [wdwr_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                 cfg_valid,
  input  logic [wdwr_pkg::CAT_W-1:0]           cfg_data,
  input  logic                                 out_tready,
  output logic                                 out_tvalid,
  output logic [wdwr_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [wdwr_pkg::SLOT_W-1:0]          out_tuser,
  output logic                                 out_tlast,
  input  wdwr_pkg::cmd_t                       cmd,
  output wdwr_pkg::stat_t                      stat
);
  import wdwr_pkg::*;

  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int TOT_W  = WGT_W + IDX_W;
  localparam int PICK_W = $clog2(PICKS + 1);
  localparam int NCMP_W = (CNT_W > CAT_W) ? CNT_W : CAT_W;
  localparam int LCMP_W = (CNT_W > IDX_FW) ? CNT_W : IDX_FW;
  localparam int CI_W   = (IDX_W > IDX_FW) ? IDX_W : IDX_FW;
  localparam int SL_W   = (PICK_W > SLOT_W) ? PICK_W : SLOT_W;

  logic [WGT_W-1:0]  mem [MAX_ENTRIES];
  logic [WGT_W-1:0]  rdata_r;

  logic [CAT_W-1:0]  cat_r;
  logic [CNT_W-1:0]  n_live;
  logic [NCMP_W-1:0] cat_ext;

  logic [IDX_FW-1:0] ld_idx;
  logic [WGT_W-1:0]  ld_wgt;
  logic [LCMP_W-1:0] ld_ext;
  logic              ld_we;

  logic [RND_W-1:0]  rnd_r [RAND_WORDS];
  logic [1:0]        rsel_r;
  logic [PICK_W-1:0] pick_r;
  logic [IDX_W-1:0]  taken_idx_r [PICKS];

  logic [CNT_W-1:0]  addr_r;
  logic              issue;
  logic              issue_taken;
  logic              rd_vld_r;
  logic              rd_taken_r;
  logic [IDX_W-1:0]  rd_idx_r;

  logic [TOT_W-1:0]  total_r;
  logic              found_r;
  logic [IDX_W-1:0]  first_r;

  logic [RND_W-1:0]     div_word_r;
  logic [TOT_W-1:0]     rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [TOT_W:0]       rem_sh;

  logic [TOT_W-1:0]  r_r;
  logic              hit_r;
  logic [IDX_W-1:0]  sel_r;

  logic [IDX_W-1:0]  pick_idx;
  logic [CI_W-1:0]   pick_ext;
  logic [SL_W-1:0]   slot_ext;

  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [SLOT_W-1:0]      out_tuser_r;
  logic                   out_tlast_r;

  assign cat_ext = NCMP_W'(cat_r);
  assign n_live  = (cat_ext > NCMP_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                    : cat_ext[CNT_W-1:0];

  assign ld_idx = in_tdata[IDX_FW-1:0];
  assign ld_wgt = in_tdata[IDX_FW +: WGT_W];
  assign ld_ext = LCMP_W'(ld_idx);
  assign ld_we  = cmd.load && (ld_ext < LCMP_W'(MAX_ENTRIES));

  // An entry is taken if an earlier pick of this roll chose it.
  always_comb begin
    issue_taken = 1'b0;
    for (int k = 0; k < PICKS; k++) begin
      if (PICK_W'(k) < pick_r && taken_idx_r[k] == addr_r[IDX_W-1:0]) issue_taken = 1'b1;
    end
  end

  assign issue = (cmd.sum_en || (cmd.scan_en && !hit_r)) && (addr_r < n_live);

  assign rem_sh   = {rem_r, div_word_r[RND_W-1]};
  assign pick_idx = hit_r ? sel_r : first_r;
  assign pick_ext = CI_W'(pick_idx);
  assign slot_ext = SL_W'(pick_r);

  always_ff @(posedge clk) begin
    if (ld_we) mem[ld_ext[IDX_W-1:0]] <= ld_wgt;
    rdata_r <= mem[addr_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cat_r <= '0;
    end else if (cfg_valid) begin
      cat_r <= cfg_data;
    end
  end

  // Walk control: address counter and read-tag pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r   <= '0;
      rd_vld_r <= 1'b0;
    end else if (cmd.sum_start || cmd.scan_start) begin
      addr_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      if (issue) addr_r <= addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= addr_r[IDX_W-1:0];
    rd_taken_r <= issue_taken;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      hit_r   <= 1'b0;
      pick_r  <= '0;
      rsel_r  <= '0;
    end else begin
      if (cmd.roll_start) begin
        pick_r <= '0;
        rsel_r <= '0;
      end else if (cmd.emit) begin
        pick_r <= pick_r + 1'b1;
        rsel_r <= (rsel_r == 2'(RAND_WORDS - 1)) ? 2'd0 : rsel_r + 2'd1;
      end
      if (cmd.sum_start) begin
        found_r <= 1'b0;
      end else if (cmd.sum_en && rd_vld_r && !rd_taken_r) begin
        found_r <= 1'b1;
      end
      if (cmd.sum_start || cmd.scan_start) begin
        hit_r <= 1'b0;
      end else if (cmd.scan_en && rd_vld_r && !rd_taken_r && !hit_r
                   && r_r < TOT_W'(rdata_r)) begin
        hit_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.roll_start) begin
      for (int w = 0; w < RAND_WORDS; w++) begin
        rnd_r[w] <= in_tdata[IDX_FW + WGT_W + w * RND_W +: RND_W];
      end
    end
    if (cmd.emit) taken_idx_r[pick_r] <= pick_idx;

    if (cmd.sum_start) begin
      total_r <= '0;
    end else if (cmd.sum_en && rd_vld_r && !rd_taken_r) begin
      total_r <= total_r + TOT_W'(rdata_r);
      if (!found_r) first_r <= rd_idx_r;
    end

    // Restoring remainder, one dividend bit per cycle.
    if (cmd.div_start) begin
      rem_r      <= '0;
      div_cnt_r  <= DIV_CNT_W'(RND_W);
      div_word_r <= rnd_r[rsel_r];
    end else if (cmd.div_en && div_cnt_r != '0) begin
      div_cnt_r  <= div_cnt_r - 1'b1;
      div_word_r <= {div_word_r[RND_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, total_r}) rem_r <= TOT_W'(rem_sh - {1'b0, total_r});
      else rem_r <= rem_sh[TOT_W-1:0];
    end

    if (cmd.scan_start) begin
      r_r <= rem_r;
    end else if (cmd.scan_en && rd_vld_r && !rd_taken_r && !hit_r) begin
      if (r_r < TOT_W'(rdata_r)) sel_r <= rd_idx_r;
      else r_r <= r_r - TOT_W'(rdata_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_tdata_r <= {1'b0, (found_r ? pick_ext[IDX_FW-1:0] : {IDX_FW{1'b0}}), found_r};
      out_tuser_r <= slot_ext[SLOT_W-1:0];
      out_tlast_r <= (pick_r == PICK_W'(PICKS - 1));
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  assign stat.walk_done  = (addr_r >= n_live) && !rd_vld_r;
  assign stat.found      = found_r;
  assign stat.total_zero = (total_r == '0);
  assign stat.div_done   = (div_cnt_r == '0);
  assign stat.scan_hit   = hit_r;
  assign stat.last_pick  = (pick_r == PICK_W'(PICKS - 1));
  assign stat.out_free   = !out_tvalid_r || out_tready;

endmodule
